[src/hsbc_pkg.sv]
// ----------------------------------------------------------------------------
// hsbc_pkg
// constants and reciprocal factors shared by the hsb to rgba converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsbc_pkg;

    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned BYTE_MAX   = 255;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned SECTORS    = 6;

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // floor(p/100) for p <= 25500 as (p*5243) >> 19
    localparam logic [12:0] RECIP_PCT       = 13'd5243;
    localparam int unsigned RECIP_PCT_SHIFT = 19;

    // floor(h/60) for h <= 511 as (h*1093) >> 16
    localparam logic [10:0] RECIP_HUE       = 11'd1093;
    localparam int unsigned RECIP_HUE_SHIFT = 16;

    // floor(p/60) for p <= 15045 as (p*17477) >> 20
    localparam logic [14:0] RECIP_SEC       = 15'd17477;
    localparam int unsigned RECIP_SEC_SHIFT = 20;

    typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

[src/hsbc_pct_scale.sv]
// ----------------------------------------------------------------------------
// hsbc_pct_scale
// signed percent to byte: magnitude, clamp to 100, then scale by 255/100
// ----------------------------------------------------------------------------
`default_nettype none

module hsbc_pct_scale
(
    input  wire logic [7:0]     pct,
    output hsbc_pkg::byte_t     level
);
    import hsbc_pkg::*;

    logic [8:0]  mag;
    logic [6:0]  clamped;
    logic [14:0] scaled;
    logic [27:0] prod;

    always_comb
    begin
        if (pct[7])
        begin
            mag = 9'd256 - {1'b0, pct};
        end
        else
        begin
            mag = {1'b0, pct};
        end
        if (mag > 9'(PCT_FULL))
        begin
            clamped = 7'(PCT_FULL);
        end
        else
        begin
            clamped = mag[6:0];
        end
        // times 255 as times 256 minus one
        scaled = {clamped, 8'd0} - {8'd0, clamped};
        prod   = 28'(scaled) * 28'(RECIP_PCT);
        level  = prod[RECIP_PCT_SHIFT +: 8];
    end

endmodule

`default_nettype wire

[src/hsb_to_rgba_convert.sv]
// ----------------------------------------------------------------------------
// hsb_to_rgba_convert
// hue, saturation and brightness to a packed rgb word with constant alpha
// ----------------------------------------------------------------------------
// a request passes through the five-stage multiply pipeline to the output
// throughput: one request per cycle unless the output stalls
// the whole pipeline holds while the output result waits under stall
// reset clears every stage valid bit; data registers are not reset
`default_nettype none

module hsb_to_rgba_convert
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [8:0]  hue,
    input  wire logic [7:0]  saturation,
    input  wire logic [7:0]  brightness,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      rgba_word
);
    import hsbc_pkg::*;

    logic [4:0] valid_reg;
    logic [4:0] valid_next;
    logic       adv;

    // stage 1
    byte_t       s_lvl;
    byte_t       v_lvl;
    logic [19:0] hue_prod;
    logic [8:0]  hue1_reg;
    logic [3:0]  sec1_reg;
    byte_t       s1_reg;
    byte_t       v1_reg;

    // stage 2
    logic [8:0]  sec_base;
    logic [8:0]  rem_full;
    logic [5:0]  rem2_reg;
    logic [3:0]  sec2_reg;
    logic [15:0] mp2_reg;
    byte_t       v2_reg;
    logic        grey2_reg;

    // stage 3
    logic [16:0] m_sum;
    byte_t       m_val;
    byte_t       m3_reg;
    byte_t       d3_reg;
    byte_t       v3_reg;
    logic [5:0]  rem3_reg;
    logic [3:0]  sec3_reg;
    logic        grey3_reg;

    // stage 4
    logic [13:0] xp4_reg;
    byte_t       m4_reg;
    byte_t       v4_reg;
    logic [3:0]  sec4_reg;
    logic        grey4_reg;

    // stage 5
    logic [28:0] x_prod;
    byte_t       x_val;
    byte_t       up_val;
    byte_t       down_val;
    logic [23:0] rgb;
    logic [31:0] rgba_reg;
    logic [31:0] rgba_next;

    assign adv        = !(valid_reg[4] && out_stall);
    assign in_stall   = !adv;
    assign out_valid  = valid_reg[4];
    assign rgba_word  = rgba_reg;
    assign valid_next = {valid_reg[3:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    hsbc_pct_scale u_sat
    (
        .pct   (saturation),
        .level (s_lvl)
    );

    hsbc_pct_scale u_bri
    (
        .pct   (brightness),
        .level (v_lvl)
    );

    assign hue_prod = 20'(hue) * 20'(RECIP_HUE);
    assign sec_base = 9'(sec1_reg) * 9'(SECTOR_DEG);
    assign rem_full = hue1_reg - sec_base;

    // exact divide by 255 for products of two bytes
    assign m_sum = 17'(mp2_reg) + 17'(mp2_reg[15:8]) + 17'd1;
    assign m_val = m_sum[15:8];

    assign x_prod   = 29'(xp4_reg) * 29'(RECIP_SEC);
    assign x_val    = x_prod[RECIP_SEC_SHIFT +: 8];
    assign up_val   = m4_reg + x_val;
    assign down_val = v4_reg - x_val;

    always_comb
    begin
        if (grey4_reg)
        begin
            rgb = {v4_reg, v4_reg, v4_reg};
        end
        else
        begin
            case (sec4_reg)
                4'd0:    rgb = {up_val, m4_reg, m4_reg};
                4'd1:    rgb = {v4_reg, m4_reg, down_val};
                4'd2:    rgb = {v4_reg, up_val, m4_reg};
                4'd3:    rgb = {down_val, v4_reg, m4_reg};
                4'd4:    rgb = {m4_reg, v4_reg, up_val};
                4'd5:    rgb = {m4_reg, down_val, v4_reg};
                default: rgb = '0;
            endcase
        end
        rgba_next = {rgb, ALPHA_BYTE};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue1_reg  <= hue;
            sec1_reg  <= hue_prod[RECIP_HUE_SHIFT +: 4];
            s1_reg    <= s_lvl;
            v1_reg    <= v_lvl;

            rem2_reg  <= rem_full[5:0];
            sec2_reg  <= sec1_reg;
            mp2_reg   <= 16'(8'(BYTE_MAX) - s1_reg) * 16'(v1_reg);
            v2_reg    <= v1_reg;
            grey2_reg <= (s1_reg == 8'd0);

            m3_reg    <= m_val;
            d3_reg    <= v2_reg - m_val;
            v3_reg    <= v2_reg;
            rem3_reg  <= rem2_reg;
            sec3_reg  <= sec2_reg;
            grey3_reg <= grey2_reg;

            xp4_reg   <= 14'(rem3_reg) * 14'(d3_reg);
            m4_reg    <= m3_reg;
            v4_reg    <= v3_reg;
            sec4_reg  <= sec3_reg;
            grey4_reg <= grey3_reg;

            rgba_reg  <= rgba_next;
        end
    end

endmodule

`default_nettype wire

[tb/hsb_to_rgba_convert_test.sv]
// ----------------------------------------------------------------------------
// hsb_to_rgba_convert_test
// self-checking bench for the hsb to rgba converter: a scoreboard predicts
// each packed colour word from the accepted request, directed corners and
// sector edges come first, then random requests with idling on both sides,
// a long output hold that backs the pipeline up, and a drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsb_to_rgba_convert_test;

    import hsbc_pkg::*;

    localparam int unsigned LATENCY_CYCLES   = 5;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT      = 2000;

    class rgba_scoreboard;
        logic [31:0] expected_words[$];
        int unsigned mismatches = 0;
        int unsigned noted = 0;
        int unsigned checked = 0;
        int unsigned grey_count = 0;
        int unsigned no_colour_count = 0;

        static function int unsigned pct_level(logic [7:0] raw);
            int unsigned mag;
            mag = raw[7] ? 256 - raw : raw;
            if (mag > PCT_FULL)
            begin
                mag = PCT_FULL;
            end
            return mag * BYTE_MAX / PCT_FULL;
        endfunction

        static function logic [31:0] predict_rgba(logic [8:0] h, logic [7:0] s_raw,
                                                  logic [7:0] b_raw);
            int unsigned sat;
            int unsigned val;
            int unsigned low;
            int unsigned ramp;
            int unsigned rise;
            int unsigned fall;
            byte_t r;
            byte_t g;
            byte_t b;
            sat = pct_level(s_raw);
            val = pct_level(b_raw);
            r = '0;
            g = '0;
            b = '0;
            if (sat == 0)
            begin
                r = byte_t'(val);
                g = byte_t'(val);
                b = byte_t'(val);
            end
            else
            begin
                low  = (BYTE_MAX - sat) * val / BYTE_MAX;
                ramp = (h % SECTOR_DEG) * (val - low) / SECTOR_DEG;
                rise = low + ramp;
                fall = val - ramp;
                if (h < SECTOR_DEG)
                begin
                    r = byte_t'(rise); g = byte_t'(low);  b = byte_t'(low);
                end
                else if (h < 2 * SECTOR_DEG)
                begin
                    r = byte_t'(val);  g = byte_t'(low);  b = byte_t'(fall);
                end
                else if (h < 3 * SECTOR_DEG)
                begin
                    r = byte_t'(val);  g = byte_t'(rise); b = byte_t'(low);
                end
                else if (h < 4 * SECTOR_DEG)
                begin
                    r = byte_t'(fall); g = byte_t'(val);  b = byte_t'(low);
                end
                else if (h < 5 * SECTOR_DEG)
                begin
                    r = byte_t'(low);  g = byte_t'(val);  b = byte_t'(rise);
                end
                else if (h < SECTORS * SECTOR_DEG)
                begin
                    r = byte_t'(low);  g = byte_t'(fall); b = byte_t'(val);
                end
            end
            return {r, g, b, ALPHA_BYTE};
        endfunction

        function void note_request(logic [8:0] h, logic [7:0] s_raw, logic [7:0] b_raw);
            expected_words.push_back(predict_rgba(h, s_raw, b_raw));
            noted++;
            if (pct_level(s_raw) == 0)
            begin
                grey_count++;
            end
            else if (h >= SECTORS * SECTOR_DEG)
            begin
                no_colour_count++;
            end
        endfunction

        function void check_word(logic [31:0] actual);
            logic [31:0] expected;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %08h", $time, actual);
                mismatches++;
                return;
            end
            expected = expected_words.pop_front();
            checked++;
            if (actual !== expected)
            begin
                $display("%0t rgba_word mismatch: expected %08h actual %08h",
                         $time, expected, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [8:0]  hue = '0;
    logic [7:0]  saturation = '0;
    logic [7:0]  brightness = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] rgba_word;

    bit hold_long = 1'b0;
    bit quiet = 1'b0;

    rgba_scoreboard sb = new();

    hsb_to_rgba_convert i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rgba_word  (rgba_word)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    task automatic send_request(input logic [8:0] h, input logic [7:0] s,
                                input logic [7:0] b, input bit may_idle);
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(h, s, b);
        if (may_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_percent();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 8'h7F;
                    1: return 8'h80;
                    2: return 8'd100;
                    default: return 8'h9C;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_request(input bit may_idle);
        logic [8:0] h;
        logic [7:0] s;
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0)
        begin
            h = 9'($urandom_range(0, SECTORS * SECTOR_DEG - 1));
        end
        else
        begin
            h = 9'($urandom_range(SECTORS * SECTOR_DEG, 511));
        end
        s = pick_percent();
        b = pick_percent();
        send_request(h, s, b, may_idle);
    endtask

    // results are taken and stall is chosen at each rising edge
    initial
    begin : receiver
        int unsigned stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_word(rgba_word);
            end
            if (hold_long && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11);
            end
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin : stimulus
        logic [8:0] corner_hues[14];
        int unsigned wait_cycles;
        corner_hues = '{9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd179, 9'd180,
                        9'd239, 9'd240, 9'd299, 9'd300, 9'd359, 9'd360, 9'd511};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector edges at full saturation and brightness
        for (int i = 0; i < 14; i++)
        begin
            send_request(corner_hues[i], 8'd100, 8'd100, 1'b1);
        end
        // grey beats out-of-range hue, magnitudes and percent clamping
        send_request(9'd400, 8'h00, 8'd100, 1'b1);
        send_request(9'd0,   8'h00, 8'h80,  1'b1);
        send_request(9'd90,  8'h80, 8'h7F,  1'b1);
        send_request(9'd30,  8'h9C, 8'h9C,  1'b1);
        send_request(9'd200, 8'h65, 8'h9B,  1'b1);
        send_request(9'd330, 8'h01, 8'hFF,  1'b1);
        send_request(9'd150, 8'd50, 8'h00,  1'b1);
        send_request(9'd511, 8'hFF, 8'h7F,  1'b1);

        repeat (700) send_random_request(1'b1);

        // let the pipeline empty completely
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
        begin
            @(posedge clk);
        end

        // long output hold while requests keep coming
        hold_long = 1'b1;
        repeat (60) send_random_request(1'b0);

        repeat (600) send_random_request(1'b1);

        quiet = 1'b1;
        repeat (100) send_random_request(1'b0);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.expected_words.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d grey, %0d with hue past the last sector",
                 sb.noted, sb.grey_count, sb.no_colour_count);
        $display("checked %0d results, %0d mismatches, %0d still outstanding",
                 sb.checked, sb.mismatches, sb.expected_words.size());
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("%0t timeout with %0d results outstanding", $time,
                 sb.expected_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
